FILE: rtl/core/lhr_pkg.sv
// Shared types and constants of the line history ring.
package lhr_pkg;

  localparam int LHR_ENTRIES  = 16;
  localparam int LHR_LINE_LEN = 63;
  localparam int LHR_CHAR_W   = 8;
  localparam int LHR_LIMIT_W  = 7;
  localparam logic [LHR_LIMIT_W-1:0] LHR_LIMIT_RST = 7'd64;

  typedef enum logic [1:0] {
    RQ_ADD    = 2'd0,
    RQ_PREV   = 2'd1,
    RQ_NEXT   = 2'd2,
    RQ_CURSOR = 2'd3
  } lhr_req_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NONE    = 2'd1,
    ST_STORED  = 2'd2,
    ST_IGNORED = 2'd3
  } lhr_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_ADD_CMP,
    S_ADD_END,
    S_COPY,
    S_COPY_FIN,
    S_LEN,
    S_RD,
    S_PUT,
    S_RESP
  } lhr_state_t;

  typedef struct packed {
    logic        latch;
    logic        stg_wr;
    logic        stg_ovf;
    logic        cmp;
    logic        stg_clr;
    logic        cp_start;
    logic        cp_step;
    logic        commit;
    logic        brw_clr;
    logic        brw_set;
    logic        len_rd;
    logic        cut_ld;
    logic        chr_rd;
    logic        chr_adv;
    logic        out_ld;
    logic        out_chr;
    lhr_status_t out_st;
  } lhr_cmd_t;

  typedef struct packed {
    lhr_req_t req;
    logic     chv;
    logic     last;
    logic     stg_full;
    logic     stg_empty;
    logic     equal;
    logic     ring_empty;
    logic     prev_ok;
    logic     next_ok;
    logic     cp_last;
    logic     cut_zero;
    logic     chr_last;
    logic     out_free;
  } lhr_sts_t;

endpackage

FILE: rtl/core/line_history_ring.sv
// Top level of the line history ring: command-line history with a browse cursor.
//
//  channel | direction | handshake                   | payload
//  in_     | request   | in_tvalid / in_tready       | tdata char_in, tuser req_type/char_valid,
//          |           |                             | tlast line_last
//  out_    | result    | out_tvalid / out_tready     | tdata out_char, tuser status/out_valid,
//          |           |                             | tlast out_last
//  cfg_    | write     | cfg_we                      | cfg_wdata out_limit
//
// An add character is latched, then decoded, then compared against the newest entry through the
// registered line memory read; with no character or past the line limit the compare is skipped.
// Closing a stored line copies L characters from staging, then returns the status result.
// A recall fetches the length, then reads and puts out each character in turn, as the line
// memory has a single read port. No clearing pass after reset; an unwritten line memory read
// is masked by the entry count and the newest length.
// A stalled result register holds the controller only when another result is due.
module line_history_ring import lhr_pkg::*; #(
  parameter int ENTRIES  = LHR_ENTRIES,
  parameter int LINE_LEN = LHR_LINE_LEN
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [LHR_CHAR_W-1:0]  in_tdata,   // [7:0] char_in
  input  logic [2:0]             in_tuser,   // [1:0] req_type, [2] char_valid
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [LHR_CHAR_W-1:0]  out_tdata,  // [7:0] out_char
  output logic [2:0]             out_tuser,  // [1:0] status, [2] out_valid
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [LHR_LIMIT_W-1:0] cfg_wdata
);

  lhr_cmd_t cmd;
  lhr_sts_t sts;

  lhr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lhr_dp #(
    .ENTRIES  (ENTRIES),
    .LINE_LEN (LINE_LEN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while the previous one is in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_tvalid || out_tready))
    else $error("pending result overwritten");

  a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stg_wr |-> !sts.stg_full)
    else $error("staging write past the line limit");

  a_copy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cp_step |-> !sts.stg_empty)
    else $error("copy of an empty staged line");

endmodule

FILE: rtl/core/lhr_dp.sv
// Datapath of the line history ring: line memories, cursor, staging and result register.
module lhr_dp import lhr_pkg::*; #(
  parameter int ENTRIES  = LHR_ENTRIES,
  parameter int LINE_LEN = LHR_LINE_LEN
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [LHR_CHAR_W-1:0]  in_tdata,
  input  logic [2:0]             in_tuser,
  input  logic                   in_tlast,
  input  logic                   cfg_we,
  input  logic [LHR_LIMIT_W-1:0] cfg_wdata,
  input  lhr_cmd_t               cmd,
  output lhr_sts_t               sts,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [LHR_CHAR_W-1:0]  out_tdata,
  output logic [2:0]             out_tuser,
  output logic                   out_tlast
);

  localparam int IW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int SW    = IW + 1;
  localparam int LW    = $clog2(LINE_LEN + 1);
  localparam int PW    = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
  localparam int DEPTH = ENTRIES * LINE_LEN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [LHR_CHAR_W-1:0]  store_mem [DEPTH];
  logic [LHR_CHAR_W-1:0]  stg_mem   [LINE_LEN];
  logic [LW-1:0]          len_mem   [ENTRIES];

  lhr_req_t               req_r;
  logic [LHR_CHAR_W-1:0]  ch_r;
  logic                   chv_r;
  logic                   last_r;
  logic [LHR_LIMIT_W-1:0] lim_r;
  logic [LW-1:0]          stg_len_r;
  logic                   stg_diff_r;
  logic [IW-1:0]          wslot_r;
  logic [CW-1:0]          cnt_r;
  logic                   act_r;
  logic [IW-1:0]          pos_r;
  logic [LW-1:0]          newest_len_r;
  logic [IW-1:0]          slot_r;
  logic [LW-1:0]          cut_r;
  logic [LW-1:0]          cut_nxt;
  logic [PW-1:0]          idx_r;
  logic [PW-1:0]          cp_r;
  logic                   cpw_r;
  logic [PW-1:0]          cpa_r;
  logic [LHR_CHAR_W-1:0]  store_q;
  logic [LHR_CHAR_W-1:0]  stg_q;
  logic [LW-1:0]          len_q;
  logic                   ov_r;
  lhr_status_t            ost_r;
  logic [LHR_CHAR_W-1:0]  och_r;
  logic                   ocv_r;
  logic                   olast_r;

  logic [CW-1:0]          nxt_age;
  logic [CW-1:0]          tgt_age;
  logic [IW-1:0]          newest_slot;
  logic [AW-1:0]          rd_addr;
  logic [LHR_LIMIT_W-1:0] cap;
  logic [LHR_LIMIT_W-1:0] len_ext;
  logic [LHR_LIMIT_W-1:0] cut_wide;
  logic                   chr_last;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] ws, input logic [CW-1:0] age);
    logic [SW-1:0] t;
    t = SW'(ws) + SW'(ENTRIES - 1) - SW'(age);
    if (t >= SW'(ENTRIES)) begin
      t = t - SW'(ENTRIES);
    end
    return t[IW-1:0];
  endfunction

  function automatic logic [AW-1:0] base_of(input logic [IW-1:0] s);
    return AW'(s) * AW'(LINE_LEN);
  endfunction

  assign nxt_age     = act_r ? (CW'(pos_r) + CW'(1)) : '0;
  assign tgt_age     = (req_r == RQ_PREV) ? nxt_age : (CW'(pos_r) - CW'(1));
  assign newest_slot = slot_of(wslot_r, '0);
  assign rd_addr     = cmd.chr_rd ? (base_of(slot_r) + AW'(idx_r))
                                  : (base_of(newest_slot) + AW'(stg_len_r));
  assign cap         = (lim_r == '0) ? '0 : (lim_r - 1'b1);
  assign len_ext     = LHR_LIMIT_W'(len_q);
  assign cut_wide    = (len_ext > cap) ? cap : len_ext;
  assign cut_nxt     = cut_wide[LW-1:0];
  assign chr_last    = ((LW'(idx_r) + LW'(1)) == cut_r);

  always_comb begin
    sts.req        = req_r;
    sts.chv        = chv_r;
    sts.last       = last_r;
    sts.stg_full   = (stg_len_r >= LW'(LINE_LEN));
    sts.stg_empty  = (stg_len_r == '0);
    sts.equal      = (stg_len_r != '0) && (cnt_r != '0) && !stg_diff_r &&
                     (stg_len_r == newest_len_r);
    sts.ring_empty = (cnt_r == '0);
    sts.prev_ok    = (nxt_age < cnt_r);
    sts.next_ok    = act_r && (pos_r != '0);
    sts.cp_last    = ((LW'(cp_r) + LW'(1)) == stg_len_r);
    sts.cut_zero   = (cut_nxt == '0);
    sts.chr_last   = chr_last;
    sts.out_free   = !ov_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= lhr_req_t'(in_tuser[1:0]);
      ch_r   <= in_tdata;
      chv_r  <= in_tuser[2] && (in_tdata != '0);
      last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= LHR_LIMIT_RST;
    end else if (cfg_we) begin
      lim_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_len_r  <= '0;
      stg_diff_r <= 1'b0;
    end else if (cmd.stg_clr) begin
      stg_len_r  <= '0;
      stg_diff_r <= 1'b0;
    end else if (cmd.cmp) begin
      stg_len_r <= stg_len_r + LW'(1);
      if ((cnt_r != '0) && ((stg_len_r >= newest_len_r) || (store_q != ch_r))) begin
        stg_diff_r <= 1'b1;
      end
    end else if (cmd.stg_ovf) begin
      stg_diff_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r <= '0;
      cnt_r   <= '0;
    end else if (cmd.commit) begin
      wslot_r <= (wslot_r == IW'(ENTRIES - 1)) ? '0 : (wslot_r + IW'(1));
      if (cnt_r != CW'(ENTRIES)) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      newest_len_r <= stg_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      pos_r <= '0;
    end else if (cmd.brw_clr) begin
      act_r <= 1'b0;
    end else if (cmd.brw_set) begin
      act_r <= 1'b1;
      pos_r <= tgt_age[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.len_rd) begin
      slot_r <= slot_of(wslot_r, tgt_age);
    end
    if (cmd.cut_ld) begin
      cut_r <= cut_nxt;
      idx_r <= '0;
    end else if (cmd.chr_adv) begin
      idx_r <= idx_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cp_start) begin
      cp_r <= '0;
    end else if (cmd.cp_step) begin
      cp_r <= cp_r + PW'(1);
    end
    cpa_r <= cp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpw_r <= 1'b0;
    end else begin
      cpw_r <= cmd.cp_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stg_wr) begin
      stg_mem[stg_len_r[PW-1:0]] <= ch_r;
    end
    if (cmd.cp_step) begin
      stg_q <= stg_mem[cp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cpw_r) begin
      store_mem[base_of(wslot_r) + AW'(cpa_r)] <= stg_q;
    end
    if (cmd.stg_wr || cmd.chr_rd) begin
      store_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      len_mem[wslot_r] <= stg_len_r;
    end
    if (cmd.len_rd) begin
      len_q <= len_mem[slot_of(wslot_r, tgt_age)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_ld) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      ost_r   <= cmd.out_st;
      och_r   <= cmd.out_chr ? store_q : '0;
      ocv_r   <= cmd.out_chr;
      olast_r <= cmd.out_chr ? chr_last : 1'b1;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = och_r;
  assign out_tuser  = {ocv_r, ost_r};
  assign out_tlast  = olast_r;

endmodule

FILE: rtl/core/lhr_ctrl.sv
// Controller state machine of the line history ring.
module lhr_ctrl import lhr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  lhr_sts_t sts,
  output lhr_cmd_t cmd
);

  lhr_state_t  state_r;
  lhr_state_t  state_nxt;
  lhr_status_t resp_r;
  lhr_status_t resp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      resp_r  <= ST_DONE;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    resp_nxt  = resp_r;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.req)
          RQ_ADD: begin
            if (sts.chv && !sts.stg_full) begin
              cmd.stg_wr = 1'b1;
              state_nxt  = S_ADD_CMP;
            end else begin
              cmd.stg_ovf = sts.chv;
              state_nxt   = sts.last ? S_ADD_END : S_IDLE;
            end
          end
          RQ_PREV: begin
            if (sts.ring_empty || !sts.prev_ok) begin
              resp_nxt  = ST_NONE;
              state_nxt = S_RESP;
            end else begin
              cmd.brw_set = 1'b1;
              cmd.len_rd  = 1'b1;
              state_nxt   = S_LEN;
            end
          end
          RQ_NEXT: begin
            if (sts.ring_empty) begin
              resp_nxt  = ST_NONE;
              state_nxt = S_RESP;
            end else if (!sts.next_ok) begin
              cmd.brw_clr = 1'b1;
              resp_nxt    = ST_DONE;
              state_nxt   = S_RESP;
            end else begin
              cmd.brw_set = 1'b1;
              cmd.len_rd  = 1'b1;
              state_nxt   = S_LEN;
            end
          end
          default: begin
            cmd.brw_clr = 1'b1;
            resp_nxt    = ST_DONE;
            state_nxt   = S_RESP;
          end
        endcase
      end
      S_ADD_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = sts.last ? S_ADD_END : S_IDLE;
      end
      S_ADD_END: begin
        if (sts.stg_empty) begin
          cmd.stg_clr = 1'b1;
          resp_nxt    = ST_IGNORED;
          state_nxt   = S_RESP;
        end else if (sts.equal) begin
          cmd.stg_clr = 1'b1;
          cmd.brw_clr = 1'b1;
          resp_nxt    = ST_IGNORED;
          state_nxt   = S_RESP;
        end else begin
          cmd.cp_start = 1'b1;
          state_nxt    = S_COPY;
        end
      end
      S_COPY: begin
        cmd.cp_step = 1'b1;
        if (sts.cp_last) begin
          state_nxt = S_COPY_FIN;
        end
      end
      S_COPY_FIN: begin
        cmd.commit  = 1'b1;
        cmd.brw_clr = 1'b1;
        cmd.stg_clr = 1'b1;
        resp_nxt    = ST_STORED;
        state_nxt   = S_RESP;
      end
      S_LEN: begin
        cmd.cut_ld = 1'b1;
        if (sts.cut_zero) begin
          resp_nxt  = ST_DONE;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.chr_rd = 1'b1;
        state_nxt  = S_PUT;
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.out_ld  = 1'b1;
          cmd.out_chr = 1'b1;
          cmd.out_st  = ST_DONE;
          cmd.chr_adv = 1'b1;
          state_nxt   = sts.chr_last ? S_IDLE : S_RD;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          cmd.out_st = resp_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: tb/sv/tb_line_history_ring.sv
// Self-checking testbench for line_history_ring: random streamed requests against a predictor.
`timescale 1ns / 1ps

module tb_line_history_ring;
  import lhr_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE_WAIT  = 24;
  localparam int PHASE_ITEMS  = 64;
  localparam int PHASES       = 7;

  typedef struct {
    lhr_req_t   rq;
    logic [7:0] ch;
    logic       chv;
    logic       last;
  } request_t;

  typedef struct {
    lhr_status_t st;
    logic [7:0]  ch;
    logic        vld;
    logic        last;
  } result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [LHR_CHAR_W-1:0]  in_tdata = '0;   // [7:0] char_in
  logic [2:0]             in_tuser = '0;   // [1:0] req_type, [2] char_valid
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [LHR_CHAR_W-1:0]  out_tdata;       // [7:0] out_char
  logic [2:0]             out_tuser;       // [1:0] status, [2] out_valid
  logic                   out_tlast;
  logic                   cfg_we = 1'b0;
  logic [LHR_LIMIT_W-1:0] cfg_wdata = '0;

  line_history_ring dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  request_t   pending_requests[$];
  result_t    due_results[$];
  logic [7:0] line_buf[$];
  logic [7:0] last_sent[$];
  int         queued_items = 0;
  int         error_count = 0;
  int         quiet_cycles = 0;
  int         hold_asked = 0;
  int         hold_seen = 0;
  int         in_gap = 0;
  int         out_stall = 0;
  bit         in_dense = 1'b0;
  bit         out_dense = 1'b0;

  // history predictor state
  logic [7:0]             hist_chars [LHR_ENTRIES][LHR_LINE_LEN];
  int                     hist_len [LHR_ENTRIES];
  logic [7:0]             stage_chars [LHR_LINE_LEN];
  int                     stage_len;
  bit                     stage_differs;
  int                     wr_slot;
  int                     n_entries;
  int                     cursor;
  logic [LHR_LIMIT_W-1:0] lim_model;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int slot_of(int age);
    return (wr_slot + LHR_ENTRIES - 1 - (age % LHR_ENTRIES)) % LHR_ENTRIES;
  endfunction

  function automatic void owe_result(lhr_status_t st, logic [7:0] ch, logic vld, logic last);
    due_results.push_back('{st, ch, vld, last});
  endfunction

  function automatic void recall_entry(int age);
    int slot, len, cap, k;
    slot = slot_of(age);
    len = hist_len[slot];
    cap = (lim_model == 0) ? 0 : int'(lim_model) - 1;
    if (len > cap) len = cap;
    if (len == 0) begin
      owe_result(ST_DONE, 8'h00, 1'b0, 1'b1);
    end else begin
      for (k = 0; k < len; k++) begin
        owe_result(ST_DONE, hist_chars[slot][k], 1'b1, k == len - 1);
      end
    end
  endfunction

  function automatic void track_request(lhr_req_t rq, logic [7:0] ch, logic chv, logic last);
    int pos, newest, slot, nxt;
    bit has_char, empty, equal;
    has_char = chv && (ch != 8'h00);
    case (rq)
      RQ_ADD: begin
        if (has_char) begin
          pos = stage_len;
          if (pos >= LHR_LINE_LEN) begin
            stage_differs = 1'b1;
          end else begin
            stage_chars[pos] = ch;
            stage_len = pos + 1;
            if (n_entries > 0) begin
              newest = slot_of(0);
              if (pos >= hist_len[newest] || hist_chars[newest][pos] != ch) stage_differs = 1'b1;
            end
          end
        end
        if (last) begin
          empty = (stage_len == 0);
          equal = !empty && n_entries > 0 && !stage_differs && stage_len == hist_len[slot_of(0)];
          if (empty) begin
            owe_result(ST_IGNORED, 8'h00, 1'b0, 1'b1);
          end else if (equal) begin
            cursor = -1;
            owe_result(ST_IGNORED, 8'h00, 1'b0, 1'b1);
          end else begin
            slot = wr_slot;
            for (pos = 0; pos < stage_len; pos++) hist_chars[slot][pos] = stage_chars[pos];
            hist_len[slot] = stage_len;
            wr_slot = (slot + 1) % LHR_ENTRIES;
            if (n_entries < LHR_ENTRIES) n_entries++;
            cursor = -1;
            owe_result(ST_STORED, 8'h00, 1'b0, 1'b1);
          end
          stage_len = 0;
          stage_differs = 1'b0;
        end
      end
      RQ_PREV: begin
        nxt = (cursor < 0) ? 0 : cursor + 1;
        if (n_entries == 0 || nxt >= n_entries) begin
          owe_result(ST_NONE, 8'h00, 1'b0, 1'b1);
        end else begin
          cursor = nxt;
          recall_entry(nxt);
        end
      end
      RQ_NEXT: begin
        if (n_entries == 0) begin
          owe_result(ST_NONE, 8'h00, 1'b0, 1'b1);
        end else if (cursor <= 0) begin
          cursor = -1;
          owe_result(ST_DONE, 8'h00, 1'b0, 1'b1);
        end else begin
          cursor--;
          recall_entry(cursor);
        end
      end
      default: begin
        cursor = -1;
        owe_result(ST_DONE, 8'h00, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // predict on every accepted request and track register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      stage_len = 0;
      stage_differs = 1'b0;
      wr_slot = 0;
      n_entries = 0;
      cursor = -1;
      lim_model = LHR_LIMIT_RST;
    end else begin
      if (cfg_we) lim_model = cfg_wdata;
      if (in_tvalid && in_tready) begin
        track_request(lhr_req_t'(in_tuser[1:0]), in_tdata, in_tuser[2], in_tlast);
      end
    end
  end

  always @(posedge clk) begin : sender
    request_t next_req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap != 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        next_req = pending_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= next_req.ch;
        in_tuser <= {next_req.chv, next_req.rq};
        in_tlast <= next_req.last;
        if ($urandom_range(0, 49) == 0) in_dense = !in_dense;
        in_gap = in_dense ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = 0;
    end else if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      out_stall = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (out_stall != 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 49) == 0) out_dense = !out_dense;
      out_stall = out_dense ? 0 : pick_gap();
      out_tready <= (out_stall == 0);
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected result: status %0d char %02h valid %0b last %0b",
                   out_tuser[1:0], out_tdata, out_tuser[2], out_tlast);
        end
      end else begin
        want = due_results.pop_front();
        if (out_tuser[1:0] !== want.st || out_tdata !== want.ch ||
            out_tuser[2] !== want.vld || out_tlast !== want.last) begin
          error_count++;
          if (error_count <= 10) begin
            $display("result mismatch: expected status %0d char %02h valid %0b last %0b, got status %0d char %02h valid %0b last %0b",
                     want.st, want.ch, want.vld, want.last,
                     out_tuser[1:0], out_tdata, out_tuser[2], out_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void push_item(lhr_req_t rq, logic [7:0] ch, logic chv, logic last);
    pending_requests.push_back('{rq, ch, chv, last});
    queued_items++;
  endfunction

  function automatic void push_noisy(lhr_req_t rq);
    push_item(rq, 8'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  function automatic void send_line(bit noisy);
    int k;
    bit close_late;
    close_late = (line_buf.size() != 0) && ($urandom_range(0, 7) == 0);
    if (line_buf.size() == 0) begin
      if ($urandom_range(0, 1) == 0) push_item(RQ_ADD, 8'($urandom), 1'b0, 1'b1);
      else push_item(RQ_ADD, 8'h00, 1'b1, 1'b1);
      return;
    end
    for (k = 0; k < line_buf.size(); k++) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: push_item(RQ_ADD, 8'($urandom), 1'b0, 1'b0);
          1: push_item(RQ_ADD, 8'h00, 1'b1, 1'b0);
          default: push_noisy(lhr_req_t'(2'($urandom_range(1, 3))));
        endcase
      end
      push_item(RQ_ADD, line_buf[k], 1'b1, !close_late && k == line_buf.size() - 1);
    end
    if (close_late) push_item(RQ_ADD, 8'($urandom), 1'b0, 1'b1);
  endfunction

  function automatic void add_random_request();
    int r, kind, n, k;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      kind = $urandom_range(0, 19);
      line_buf.delete();
      if (kind < 3 && last_sent.size() != 0) begin
        line_buf = last_sent;
      end else if (kind == 3 && last_sent.size() > 1) begin
        line_buf = last_sent;
        void'(line_buf.pop_back());
      end else if (kind == 4 && last_sent.size() != 0) begin
        line_buf = last_sent;
        line_buf.push_back(8'($urandom_range(1, 255)));
      end else if (kind == 5) begin
        line_buf.delete();
      end else begin
        n = (kind == 6) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        for (k = 0; k < n; k++) line_buf.push_back(8'($urandom_range(1, 255)));
      end
      if (line_buf.size() != 0) last_sent = line_buf;
      send_line($urandom_range(0, 3) == 0);
    end else if (r < 80) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
      for (k = 0; k < n; k++) push_noisy(($urandom_range(0, 2) != 0) ? RQ_PREV : RQ_NEXT);
    end else if (r < 90) begin
      push_noisy(RQ_CURSOR);
    end else begin
      push_noisy(lhr_req_t'(2'($urandom)));
    end
  endfunction

  task automatic settle();
    while (pending_requests.size() != 0 || in_tvalid || due_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic write_limit(logic [LHR_LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [LHR_LIMIT_W-1:0] limits [PHASES];
    int ph, stop_at;
    limits = '{7'd1, 7'd0, 7'd127, 7'd2, 7'($urandom_range(3, 62)), 7'd64,
               7'($urandom_range(1, 127))};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty ring, cursor reset, empty lines
    push_item(RQ_PREV, 8'h00, 1'b0, 1'b0);
    push_item(RQ_NEXT, 8'hFF, 1'b1, 1'b1);
    push_item(RQ_CURSOR, 8'hA5, 1'b1, 1'b1);
    push_item(RQ_ADD, 8'h5A, 1'b0, 1'b1);
    push_item(RQ_ADD, 8'h00, 1'b1, 1'b1);
    // store a line sent with a zero byte inside (the zero byte is dropped), then repeat it
    push_item(RQ_ADD, 8'hFF, 1'b1, 1'b0);
    push_item(RQ_ADD, 8'h00, 1'b1, 1'b0);
    push_item(RQ_ADD, 8'h01, 1'b1, 1'b1);
    push_item(RQ_ADD, 8'hFF, 1'b1, 1'b0);
    push_item(RQ_ADD, 8'h01, 1'b1, 1'b0);
    push_item(RQ_ADD, 8'h33, 1'b0, 1'b1);
    // recall between characters of a line being added
    push_item(RQ_ADD, 8'h80, 1'b1, 1'b0);
    push_item(RQ_PREV, 8'h7E, 1'b1, 1'b1);
    push_item(RQ_ADD, 8'h7F, 1'b1, 1'b1);
    // walk to the oldest entry and back past the newest
    push_item(RQ_PREV, 8'h00, 1'b0, 1'b0);
    push_item(RQ_PREV, 8'h00, 1'b0, 1'b0);
    push_item(RQ_PREV, 8'h00, 1'b0, 1'b0);
    push_item(RQ_NEXT, 8'h00, 1'b0, 1'b0);
    push_item(RQ_NEXT, 8'h00, 1'b0, 1'b0);
    push_item(RQ_NEXT, 8'h00, 1'b0, 1'b0);
    push_item(RQ_PREV, 8'h00, 1'b0, 1'b0);
    push_item(RQ_CURSOR, 8'h00, 1'b0, 1'b0);

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      write_limit(limits[ph]);
      // hold off the receiver while requests keep coming
      if (ph == 2) hold_asked <= hold_asked + 1;
      stop_at = queued_items + PHASE_ITEMS;
      while (queued_items < stop_at) add_random_request();
    end
    settle();

    if (error_count == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
